FILE: rtl/assert_macros.svh
// Assertion macros shared by the loader RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Implication checked at every rising clock edge outside reset.
`define SFL_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("sfl assertion failed");
// Implication whose consequent is checked in the cycle after the antecedent.
`define SFL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("sfl assertion failed");
`else
`define SFL_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define SFL_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: rtl/sfl_pkg.sv
// Types, codes and constants of the serial flash loader.
`default_nettype none
package sfl_pkg;

	localparam int unsigned ADDR_W    = 24;
	localparam int unsigned CFG_IDX_W = 2;

	// Host command bytes
	localparam logic [7:0] CMD_DATA    = 8'h02;
	localparam logic [7:0] CMD_ADDR    = 8'h03;
	localparam logic [7:0] CMD_RESET   = 8'h04;
	localparam logic [7:0] CMD_VERSION = 8'h05;

	// Input operations
	localparam logic OP_HOST_BYTE    = 1'b0;
	localparam logic OP_FLASH_STATUS = 1'b1;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_LOW_LIMIT  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HIGH_LIMIT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ERASE_MASK = 2'd2;

	// Number of beats in a version reply: echo plus 13 text bytes
	localparam logic [3:0] VERSION_BEATS = 4'd14;

	typedef enum logic [2:0] {
		KIND_TX      = 3'd0,
		KIND_STAGE   = 3'd1,
		KIND_PROGRAM = 3'd2,
		KIND_ERASE   = 3'd3,
		KIND_RESET   = 3'd4
	} kind_t;

	typedef enum logic [4:0] {
		PH_IDLE = 5'b00001,
		PH_ADDR = 5'b00010,
		PH_DATA = 5'b00100,
		PH_CSUM = 5'b01000,
		PH_WAIT = 5'b10000
	} phase_t;

	typedef struct packed {
		kind_t             kind;
		logic [7:0]        out_byte;
		logic [5:0]        row_index;
		logic [ADDR_W-1:0] flash_address;
		logic              erase_first;
	} result_t;

	// Version text "192-160002-E" followed by a terminating zero byte
	function automatic logic [7:0] version_char(input logic [3:0] pos);
		logic [7:0] c;
		case (pos)
			4'd0:    c = 8'h31;
			4'd1:    c = 8'h39;
			4'd2:    c = 8'h32;
			4'd3:    c = 8'h2D;
			4'd4:    c = 8'h31;
			4'd5:    c = 8'h36;
			4'd6:    c = 8'h30;
			4'd7:    c = 8'h30;
			4'd8:    c = 8'h30;
			4'd9:    c = 8'h32;
			4'd10:   c = 8'h2D;
			4'd11:   c = 8'h45;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage
`default_nettype wire

FILE: rtl/sfl_if.sv
// Channel interfaces of the serial flash loader: input, result and configuration.
`default_nettype none
interface sfl_in_if;
	logic       valid;
	logic       ready;
	logic       operation;
	logic [7:0] host_byte;
	logic       flash_ok;

	modport source (output valid, output operation, output host_byte, output flash_ok,
		input ready);
	modport sink (input valid, input operation, input host_byte, input flash_ok,
		output ready);
endinterface

interface sfl_out_if;
	logic                       valid;
	logic                       ready;
	logic [2:0]                 kind;
	logic [7:0]                 out_byte;
	logic [5:0]                 row_index;
	logic [sfl_pkg::ADDR_W-1:0] flash_address;
	logic                       erase_first;
	logic                       end_of_run;

	modport source (output valid, output kind, output out_byte, output row_index,
		output flash_address, output erase_first, output end_of_run, input ready);
	modport sink (input valid, input kind, input out_byte, input row_index,
		input flash_address, input erase_first, input end_of_run, output ready);
endinterface

interface sfl_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [sfl_pkg::CFG_IDX_W-1:0] index;
	logic [sfl_pkg::ADDR_W-1:0]    data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

FILE: rtl/serial_flash_loader_protocol.sv
// Top level of the serial flash loader protocol engine.
`default_nettype none
`include "assert_macros.svh"
// Usage
// - host (sink): one beat per host byte (operation 0) or flash program status
//   (operation 1). A beat lands in a one-deep input register.
// - result (source): one beat per result; end_of_run marks the last beat an
//   input beat causes. Input beats that cause nothing produce no result beat.
// - cfg (sink): register writes, always ready; write only while idle.
// Timing
// - An input beat is decoded from the input register as soon as the result
//   sequencer is free, and its first result shows in the cycle after it is decoded.
// - While the receiver is ready, throughput is one input beat per cycle when
//   each causes at most one result; otherwise the result sequencer sets the
//   pace, one result beat per cycle (up to 14 for the version reply).
// - When the receiver stalls, the sequencer holds its beat, the next input beat
//   waits in the input register, and host.ready drops once both are full.
// Reset
// - arst_n clears the protocol state to idle, counters and sums to zero, and
//   the limit and mask registers to their defaults. No clearing pass.
// - Sector alignment of the load address is tracked by a reciprocal pipeline
//   (prod_s1, prod_s2, aligned_q); the address is always stable long before use.
module serial_flash_loader_protocol #(
	parameter int unsigned ROW_BYTES    = 64,
	parameter int unsigned SECTOR_BYTES = 1024
) (
	input  wire         clk,
	input  wire         arst_n,
	sfl_in_if.sink      host,
	sfl_out_if.source   result,
	sfl_cfg_if.sink     cfg
);

	localparam int unsigned CNT_W = $clog2(ROW_BYTES);
	localparam int unsigned AW    = sfl_pkg::ADDR_W;

	// floor(2^32 / SECTOR_BYTES): quotient estimate is exact or one low
	localparam logic [26:0] RECIP      = 27'((64'd1 << 32) / SECTOR_BYTES);
	localparam logic [16:0] SECTOR     = 17'(SECTOR_BYTES);
	localparam logic [AW-1:0] SECTOR_A = AW'(SECTOR_BYTES);
	localparam logic [AW:0]   ROW_SPAN = (AW+1)'(ROW_BYTES - 1);

	// ---------------- configuration registers ----------------
	logic [AW-1:0] low_limit_q;
	logic [AW-1:0] high_limit_q;
	logic [AW-1:0] erase_mask_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_limit_q  <= '0;
			high_limit_q <= AW'(131071);
			erase_mask_q <= AW'(130048);
		end else if (cfg.valid) begin
			case (cfg.index)
				sfl_pkg::REG_LOW_LIMIT:  low_limit_q  <= cfg.data;
				sfl_pkg::REG_HIGH_LIMIT: high_limit_q <= cfg.data;
				sfl_pkg::REG_ERASE_MASK: erase_mask_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// ---------------- input register ----------------
	logic       valid_s1;
	logic       op_s1;
	logic [7:0] byte_s1;
	logic       ok_s1;
	logic       advance;

	assign host.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (host.valid && host.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (host.valid && host.ready) begin
			op_s1   <= host.operation;
			byte_s1 <= host.host_byte;
			ok_s1   <= host.flash_ok;
		end
	end

	// ---------------- protocol state ----------------
	sfl_pkg::phase_t phase_q, phase_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic [1:0]       acnt_q, acnt_d;
	logic [7:0]       sum_q, sum_d;
	logic [7:0]       hsum_q, hsum_d;
	logic [AW-1:0]    ashift_q, ashift_d;
	logic [AW-1:0]    load_q, load_d;

	// ---------------- sector alignment of the load address ----------------
	logic [50:0]   prod_s1;
	logic [35:0]   prod_s2;
	logic [AW-1:0] sec_rem;
	logic          aligned_q;

	assign sec_rem = load_q - prod_s2[AW-1:0];

	always_ff @(posedge clk) begin
		prod_s1   <= 51'(load_q) * 51'(RECIP);
		prod_s2   <= 36'(prod_s1[50:32]) * 36'(SECTOR);
		aligned_q <= (sec_rem == '0) || (sec_rem == SECTOR_A);
	end

	// ---------------- decode: result plan for the item in s1 ----------------
	sfl_pkg::result_t r0, r1;
	logic [3:0]       plan_n;
	logic             plan_ver;
	logic [AW-1:0]    shift_next;
	logic             out_of_range;
	logic [15:0]      cnt_ext;

	assign shift_next   = {ashift_q[AW-9:0], byte_s1};
	assign out_of_range = (load_q < low_limit_q) ||
		(({1'b0, load_q} + ROW_SPAN) > {1'b0, high_limit_q});
	assign cnt_ext      = 16'(cnt_q);

	always_comb begin
		r0       = '0;
		r1       = '0;
		r0.kind  = sfl_pkg::KIND_TX;
		r1.kind  = sfl_pkg::KIND_TX;
		plan_n   = 4'd0;
		plan_ver = 1'b0;
		phase_d  = phase_q;
		cnt_d    = cnt_q;
		acnt_d   = acnt_q;
		sum_d    = sum_q;
		hsum_d   = hsum_q;
		ashift_d = ashift_q;
		load_d   = load_q;

		if (op_s1 == sfl_pkg::OP_FLASH_STATUS) begin
			if (phase_q == sfl_pkg::PH_WAIT) begin
				plan_n  = 4'd1;
				phase_d = sfl_pkg::PH_IDLE;
				if (ok_s1) begin
					r0.out_byte = sum_q;
					load_d      = load_q + AW'(ROW_BYTES);
				end else begin
					r0.out_byte = ~hsum_q;
				end
			end
		end else begin
			case (phase_q)
				sfl_pkg::PH_IDLE: begin
					// echo every command byte
					r0.out_byte = byte_s1;
					plan_n      = 4'd1;
					case (byte_s1)
						sfl_pkg::CMD_DATA: begin
							phase_d = sfl_pkg::PH_DATA;
							cnt_d   = '0;
							sum_d   = '0;
						end
						sfl_pkg::CMD_ADDR: begin
							phase_d  = sfl_pkg::PH_ADDR;
							acnt_d   = '0;
							ashift_d = '0;
						end
						sfl_pkg::CMD_RESET: begin
							r1.kind = sfl_pkg::KIND_RESET;
							plan_n  = 4'd2;
						end
						sfl_pkg::CMD_VERSION: begin
							plan_ver = 1'b1;
							plan_n   = sfl_pkg::VERSION_BEATS;
						end
						default: ;
					endcase
				end
				sfl_pkg::PH_ADDR: begin
					r0.out_byte = byte_s1;
					plan_n      = 4'd1;
					ashift_d    = shift_next;
					if (acnt_q == 2'd2) begin
						// third address byte: latch and erase at the masked address
						load_d           = shift_next;
						r1.kind          = sfl_pkg::KIND_ERASE;
						r1.flash_address = shift_next & erase_mask_q;
						plan_n           = 4'd2;
						acnt_d           = '0;
						phase_d          = sfl_pkg::PH_IDLE;
					end else begin
						acnt_d = acnt_q + 2'd1;
					end
				end
				sfl_pkg::PH_DATA: begin
					r0.kind      = sfl_pkg::KIND_STAGE;
					r0.out_byte  = byte_s1;
					r0.row_index = cnt_ext[5:0];
					plan_n       = 4'd1;
					sum_d        = sum_q + byte_s1;
					if (cnt_q == CNT_W'(ROW_BYTES - 1)) begin
						cnt_d   = '0;
						phase_d = sfl_pkg::PH_CSUM;
					end else begin
						cnt_d = cnt_q + CNT_W'(1);
					end
				end
				sfl_pkg::PH_CSUM: begin
					hsum_d      = byte_s1;
					r0.out_byte = byte_s1;
					plan_n      = 4'd2;
					if (out_of_range) begin
						r1.out_byte = sum_q + 8'd1;
						phase_d     = sfl_pkg::PH_IDLE;
					end else if (sum_q == byte_s1) begin
						r1.kind          = sfl_pkg::KIND_PROGRAM;
						r1.flash_address = load_q;
						r1.erase_first   = aligned_q;
						phase_d          = sfl_pkg::PH_WAIT;
					end else begin
						r1.out_byte = sum_q;
						phase_d     = sfl_pkg::PH_IDLE;
					end
				end
				default: ; // host byte while awaiting flash status: drop it
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= sfl_pkg::PH_IDLE;
			cnt_q    <= '0;
			acnt_q   <= '0;
			sum_q    <= '0;
			hsum_q   <= '0;
			ashift_q <= '0;
			load_q   <= '0;
		end else if (advance) begin
			phase_q  <= phase_d;
			cnt_q    <= cnt_d;
			acnt_q   <= acnt_d;
			sum_q    <= sum_d;
			hsum_q   <= hsum_d;
			ashift_q <= ashift_d;
			load_q   <= load_d;
		end
	end

	// ---------------- result sequencer ----------------
	logic             seq_valid_q;
	logic [3:0]       seq_idx_q;
	logic [3:0]       seq_last_q;
	logic             seq_ver_q;
	sfl_pkg::result_t r0_q, r1_q;
	sfl_pkg::result_t beat;
	logic             seq_is_last;
	logic             out_fire;
	logic             load_seq;

	assign seq_is_last = (seq_idx_q == seq_last_q);
	assign out_fire    = result.valid && result.ready;
	// decode the next item when the sequencer is idle or its run hands off its last beat
	assign advance     = valid_s1 && (!seq_valid_q || (out_fire && seq_is_last));
	assign load_seq    = advance && (plan_n != 4'd0);

	always_comb begin
		beat = r1_q;
		if (seq_idx_q == 4'd0) begin
			beat = r0_q;
		end else if (seq_ver_q) begin
			beat          = '0;
			beat.kind     = sfl_pkg::KIND_TX;
			beat.out_byte = sfl_pkg::version_char(seq_idx_q - 4'd1);
		end
	end

	assign result.valid         = seq_valid_q;
	assign result.kind          = beat.kind;
	assign result.out_byte      = beat.out_byte;
	assign result.row_index     = beat.row_index;
	assign result.flash_address = beat.flash_address;
	assign result.erase_first   = beat.erase_first;
	assign result.end_of_run    = seq_is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_valid_q <= 1'b0;
			seq_idx_q   <= '0;
			seq_last_q  <= '0;
			seq_ver_q   <= 1'b0;
		end else if (load_seq) begin
			seq_valid_q <= 1'b1;
			seq_idx_q   <= '0;
			seq_last_q  <= plan_n - 4'd1;
			seq_ver_q   <= plan_ver;
		end else if (out_fire) begin
			if (seq_is_last) begin
				seq_valid_q <= 1'b0;
			end else begin
				seq_idx_q <= seq_idx_q + 4'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_seq) begin
			r0_q <= r0;
			r1_q <= r1;
		end
	end

	// ---------------- assertions ----------------
	`SFL_ASSERT_IMPL(a_idx_bound, clk, arst_n, seq_valid_q, seq_idx_q <= seq_last_q)
	`SFL_ASSERT_IMPL(a_ready_full, clk, arst_n, !host.ready, valid_s1 && seq_valid_q)
	`SFL_ASSERT_NEXT(a_run_ends, clk, arst_n, out_fire && seq_is_last && !load_seq, !seq_valid_q)
	`SFL_ASSERT_IMPL(a_cnt_bound, clk, arst_n, 1'b1, cnt_q <= CNT_W'(ROW_BYTES - 1))
	`SFL_ASSERT_IMPL(a_ver_len, clk, arst_n, seq_valid_q && seq_ver_q, seq_last_q == 4'd13)

endmodule
`default_nettype wire
